// File: rtl/core/rtcal_pkg.sv
package rtcal_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_SEC_TICK = 2'd2,
    CMD_PER_TICK = 2'd3
  } cmd_t;

  // Register indexes
  localparam logic [6:0] REG_SEC    = 7'd0;
  localparam logic [6:0] REG_ASEC   = 7'd1;
  localparam logic [6:0] REG_MIN    = 7'd2;
  localparam logic [6:0] REG_AMIN   = 7'd3;
  localparam logic [6:0] REG_HOUR   = 7'd4;
  localparam logic [6:0] REG_AHOUR  = 7'd5;
  localparam logic [6:0] REG_WDAY   = 7'd6;
  localparam logic [6:0] REG_DAY    = 7'd7;
  localparam logic [6:0] REG_MONTH  = 7'd8;
  localparam logic [6:0] REG_YEAR   = 7'd9;
  localparam logic [6:0] REG_A      = 7'd10;
  localparam logic [6:0] REG_B      = 7'd11;
  localparam logic [6:0] REG_C      = 7'd12;
  localparam logic [6:0] REG_D      = 7'd13;
  localparam logic [6:0] RAM_BASE   = 7'd14;
  localparam int unsigned YEAR_SLOT = 49;
  localparam logic [7:0] YEAR_SLOT_VAL = 8'd22;

  localparam logic [7:0] DONT_CARE = 8'hC0;
  localparam logic [7:0] REG_D_VAL = 8'h80;

  // Control bit positions
  localparam int CB_SET  = 7;
  localparam int CB_PIE  = 6;
  localparam int CB_AIE  = 5;
  localparam int CB_UIE  = 4;
  localparam int CB_DM   = 2;
  localparam int CB_2412 = 1;

  // Flag positions
  localparam int FL_IRQF = 3;
  localparam int FL_PF   = 2;
  localparam int FL_AF   = 1;
  localparam int FL_UF   = 0;

  // binary -> BCD, kept to 8 bits
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [7:0] tens;
    logic [7:0] units;
    logic [15:0] prod;
    begin
      // v/10 via reciprocal: (v*205)>>11 exact for v < 1024
      prod  = 16'(v) * 16'd205;
      tens  = 8'(prod[15:11]);
      units = v - 8'(tens * 8'd10);
      to_bcd = 8'({tens, 4'b0}) + units;
    end
  endfunction

  // BCD -> binary, no digit checks
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    begin
      from_bcd = 8'(8'(v[7:4]) * 8'd10) + 8'(v[3:0]);
    end
  endfunction

endpackage

// File: rtl/core/rtc_calendar_alarm_registers_unit.sv
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, command, reg_index, write_data
// out     | output    | out_valid, out_ready, read_data, irq_out, rate_select
//
// One request per cycle sustained while out_ready is high; result is registered, valid in the cycle after accept.
// Clock registers sit in flops; user RAM is a synchronous memory,
// read at the request address, its registered output feeding the result stage.
// A result held by out_ready low stalls input only when the stage is full.
// No clearing pass: RAM reset image is kept by a per-entry written bit.
// rst is synchronous, active high.
module rtc_calendar_alarm_registers_unit #(
  parameter int RAM_BYTES = 114
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [6:0] reg_index,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       irq_out,
  output logic [3:0] rate_select
);
  import rtcal_pkg::*;

  localparam int AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;

  logic [7:0] seconds, minutes, hours, weekday, day_of_month, month_number, year_number;
  logic [7:0] alarm_sec, alarm_min, alarm_hour;
  logic [3:0] flags;
  logic [7:0] control_bits;
  logic [6:0] divider_and_rate;

  logic [7:0] ram [RAM_BYTES];
  logic [RAM_BYTES-1:0] ram_written;
  logic [7:0] ram_q;

  // result stage
  logic       rd_pend;     // read data comes from ram_q
  logic       rd_ram_ok;   // entry written since reset
  logic [7:0] rd_reset_val;
  logic [7:0] rd_reg;

  logic accept;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // RAM address decode
  logic [6:0]    ram_off;
  logic          ram_hit;
  logic [AW-1:0] ram_addr;
  assign ram_off  = reg_index - RAM_BASE;
  assign ram_hit  = (reg_index >= RAM_BASE) && (32'(ram_off) < RAM_BYTES);
  assign ram_addr = ram_hit ? AW'(ram_off) : '0;

  logic bcd;
  assign bcd = !control_bits[CB_DM];

  function automatic logic [7:0] to_ext(input logic [7:0] v, input logic b);
    to_ext = b ? to_bcd(v) : v;
  endfunction

  function automatic logic [7:0] from_ext(input logic [7:0] v, input logic b);
    from_ext = b ? from_bcd(v) : v;
  endfunction

  function automatic logic [7:0] rd_hours(input logic [7:0] v, input logic alarm,
                                          input logic b, input logic h24);
    logic [7:0] t;
    begin
      t = v;
      if (!h24) begin
        if (v == 8'd0) t = 8'd12;
        else if (v == 8'd12) t = 8'h8C;
        else if (v > 8'd12) t = 8'h80 + v - 8'd12;
      end
      if (alarm && v >= DONT_CARE) rd_hours = v;
      else rd_hours = {t[7], 7'b0} | to_ext({1'b0, t[6:0]}, b);
    end
  endfunction

  function automatic logic [7:0] wr_hours(input logic [7:0] v, input logic alarm,
                                          input logic b, input logic h24);
    logic [7:0] t;
    begin
      t = from_ext({1'b0, v[6:0]}, b);
      if (!h24) begin
        if (t == 8'd12) t = 8'd0;
        if (v[7]) t = t + 8'd12;
      end
      wr_hours = (alarm && v >= DONT_CARE) ? v : t;
    end
  endfunction

  function automatic logic [7:0] rd_alarm(input logic [7:0] v, input logic b);
    rd_alarm = (v >= DONT_CARE) ? v : to_ext(v, b);
  endfunction

  function automatic logic [7:0] wr_alarm(input logic [7:0] v, input logic b);
    wr_alarm = (v >= DONT_CARE) ? v : from_ext(v, b);
  endfunction

  // days in current month, leap rule on 8-bit year
  logic [7:0] mlen;
  logic       leap;
  always_comb begin
    leap = (year_number[1:0] == 2'b00) && (year_number != 8'd100) && (year_number != 8'd200);
    case (month_number)
      8'd2:                         mlen = leap ? 8'd29 : 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11:      mlen = 8'd30;
      default:                      mlen = 8'd31;
    endcase
  end

  // second tick calendar advance
  logic [7:0] s_n, m_n, h_n, w_n, d_n, mo_n, y_n;
  logic       alarm_hit;
  always_comb begin
    s_n = seconds + 8'd1; m_n = minutes; h_n = hours; w_n = weekday;
    d_n = day_of_month; mo_n = month_number; y_n = year_number;
    if (s_n == 8'd60) begin
      s_n = 8'd0;
      m_n = minutes + 8'd1;
      if (m_n == 8'd60) begin
        m_n = 8'd0;
        h_n = hours + 8'd1;
        if (h_n == 8'd24) begin
          h_n = 8'd0;
          w_n = (weekday == 8'd7) ? 8'd1 : weekday + 8'd1;
          if (day_of_month == mlen) begin
            d_n = 8'd1;
            if (month_number == 8'd12) begin
              mo_n = 8'd1;
              y_n  = year_number + 8'd1;
            end else begin
              mo_n = month_number + 8'd1;
            end
          end else begin
            d_n = day_of_month + 8'd1;
          end
        end
      end
    end
    alarm_hit = (alarm_sec >= DONT_CARE || alarm_sec == s_n) &&
                (alarm_min >= DONT_CARE || alarm_min == m_n) &&
                (alarm_hour >= DONT_CARE || alarm_hour == h_n);
  end

  // register read mux (non-RAM)
  logic [7:0] reg_rd;
  always_comb begin
    case (reg_index)
      REG_SEC:   reg_rd = to_ext(seconds, bcd);
      REG_ASEC:  reg_rd = rd_alarm(alarm_sec, bcd);
      REG_MIN:   reg_rd = to_ext(minutes, bcd);
      REG_AMIN:  reg_rd = rd_alarm(alarm_min, bcd);
      REG_HOUR:  reg_rd = rd_hours(hours, 1'b0, bcd, control_bits[CB_2412]);
      REG_AHOUR: reg_rd = rd_hours(alarm_hour, 1'b1, bcd, control_bits[CB_2412]);
      REG_WDAY:  reg_rd = to_ext(weekday, bcd);
      REG_DAY:   reg_rd = to_ext(day_of_month, bcd);
      REG_MONTH: reg_rd = to_ext(month_number, bcd);
      REG_YEAR:  reg_rd = to_ext(year_number, bcd);
      REG_A:     reg_rd = {1'b0, divider_and_rate};
      REG_B:     reg_rd = control_bits;
      REG_C:     reg_rd = {flags, 4'b0};
      REG_D:     reg_rd = REG_D_VAL;
      default:   reg_rd = 8'd0;
    endcase
  end

  // user RAM
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(command) == CMD_WRITE && ram_hit)
      ram[ram_addr] <= write_data;
    ram_q <= ram[ram_addr];
  end

  // clock registers and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds <= 8'd0; minutes <= 8'd0; hours <= 8'd1; weekday <= 8'd6;
      day_of_month <= 8'd17; month_number <= 8'd6; year_number <= 8'd72;
      alarm_sec <= 8'd0; alarm_min <= 8'd0; alarm_hour <= 8'd0;
      flags <= 4'd0; control_bits <= 8'h06; divider_and_rate <= 7'd0;
      ram_written <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (accept) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (accept) begin
        rd_pend      <= (cmd_t'(command) == CMD_READ) && ram_hit;
        rd_reg       <= (cmd_t'(command) == CMD_READ) ? reg_rd : 8'd0;
        rd_ram_ok    <= ram_written[ram_addr];
        rd_reset_val <= (32'(ram_addr) == YEAR_SLOT) ? YEAR_SLOT_VAL : 8'd0;
        case (cmd_t'(command))
          CMD_READ: begin
            if (reg_index == REG_C) flags <= 4'd0;
          end
          CMD_WRITE: begin
            case (reg_index)
              REG_SEC:   seconds <= from_ext(write_data, bcd);
              REG_ASEC:  alarm_sec <= wr_alarm(write_data, bcd);
              REG_MIN:   minutes <= from_ext(write_data, bcd);
              REG_AMIN:  alarm_min <= wr_alarm(write_data, bcd);
              REG_HOUR:  hours <= wr_hours(write_data, 1'b0, bcd, control_bits[CB_2412]);
              REG_AHOUR: alarm_hour <= wr_hours(write_data, 1'b1, bcd, control_bits[CB_2412]);
              REG_WDAY:  weekday <= from_ext(write_data, bcd);
              REG_DAY:   day_of_month <= from_ext(write_data, bcd);
              REG_MONTH: month_number <= from_ext(write_data, bcd);
              REG_YEAR:  year_number <= from_ext(write_data, bcd);
              REG_A:     divider_and_rate <= write_data[6:0];
              REG_B:     control_bits <= write_data;
              default:   if (ram_hit) ram_written[ram_addr] <= 1'b1;
            endcase
          end
          CMD_SEC_TICK: begin
            if (!control_bits[CB_SET]) begin
              seconds <= s_n; minutes <= m_n; hours <= h_n; weekday <= w_n;
              day_of_month <= d_n; month_number <= mo_n; year_number <= y_n;
              flags <= flags
                     | (4'd1 << FL_UF)
                     | (4'(control_bits[CB_UIE]) << FL_IRQF)
                     | (4'(alarm_hit) << FL_AF)
                     | (4'(alarm_hit && control_bits[CB_AIE]) << FL_IRQF);
            end
          end
          default: begin
            flags <= flags | (4'd1 << FL_PF) | (4'(control_bits[CB_PIE]) << FL_IRQF);
          end
        endcase
      end
    end
  end

  // RAM read data is registered in ram_q: hold into rd_hold when stalled
  logic [7:0] ram_rd;
  assign ram_rd = rd_ram_ok ? ram_q : rd_reset_val;
  logic rd_pend_q;
  always_ff @(posedge clk) begin
    if (rst) rd_pend_q <= 1'b0;
    else rd_pend_q <= accept;
  end
  logic [7:0] rd_hold;
  logic       rd_hold_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hold_v <= 1'b0;
    end else if (accept) begin
      rd_hold_v <= 1'b0;
    end else if (rd_pend_q && rd_pend) begin
      rd_hold   <= ram_rd;
      rd_hold_v <= 1'b1;
    end
  end

  assign read_data   = !rd_pend ? rd_reg : (rd_hold_v ? rd_hold : ram_rd);
  assign irq_out     = flags[FL_IRQF];
  assign rate_select = divider_and_rate[3:0];

endmodule

// File: rtl/core/rtcal_checker.sv
module rtcal_assert_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       irq_out,
  input logic [3:0] rate_select
);
  import rtcal_pkg::*;

  // every request yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid) else $error("missing result");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq_out) &&
                                $stable(rate_select))
    else $error("result changed under stall");

  // non-read requests return zero data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command != CMD_READ |=> read_data == 8'd0)
    else $error("nonzero data on non-read");

  // ready whenever output stage free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("blocked while empty");

endmodule

bind rtc_calendar_alarm_registers_unit rtcal_assert_checker u_rtcal_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .command(command), .out_valid(out_valid), .out_ready(out_ready),
  .read_data(read_data), .irq_out(irq_out), .rate_select(rate_select)
);
